[rtl/plru_pkg.sv]
`timescale 1ns / 1ps
package plru_pkg;

	localparam int SLOTS_DEF         = 8;
	localparam int DOC_ID_BITS_DEF   = 16;
	localparam int OWNER_ID_BITS_DEF = 8;

	localparam int CMD_BITS      = 3;
	localparam int SLOT_IN_BITS  = 3;
	localparam int STATUS_BITS   = 2;
	localparam int CAP_BITS      = 4;
	localparam int COUNT_BITS    = 4;
	localparam int MAX_RESULTS   = 8;
	localparam int RES_CNT_BITS  = $clog2(MAX_RESULTS + 1);

	typedef enum logic [CMD_BITS-1:0] {
		CMD_ACQUIRE = 3'd0,
		CMD_RELEASE = 3'd1,
		CMD_FORGET  = 3'd2,
		CMD_LOOKUP  = 3'd3,
		CMD_READ    = 3'd4,
		CMD_TRIM    = 3'd5
	} cmd_t;

	typedef enum logic [STATUS_BITS-1:0] {
		STAT_OK        = 2'd0,
		STAT_MISSING   = 2'd1,
		STAT_PINNED    = 2'd2,
		STAT_NOT_FOUND = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		C_NOP,
		C_UNPIN,
		C_TOUCH,
		C_FILL,
		C_DROP
	} cell_op_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DISP,
		S_ACQ,
		S_SCAN,
		S_TRIM
	} state_t;

	// per-cell match flags; also the form of the ripple chain between cells
	typedef struct packed {
		logic doc;
		logic own;
		logic lru;
		logic free;
		logic sel;
	} flag_t;

endpackage

[rtl/plru_if.sv]
`timescale 1ns / 1ps
interface plru_req_if import plru_pkg::*; #(
	parameter int DOC_ID_BITS   = DOC_ID_BITS_DEF,
	parameter int OWNER_ID_BITS = OWNER_ID_BITS_DEF
);
	logic                     valid;
	logic                     ready;
	logic [CMD_BITS-1:0]      cmd;
	logic [DOC_ID_BITS-1:0]   doc_id;
	logic [OWNER_ID_BITS-1:0] owner_id;
	logic [SLOT_IN_BITS-1:0]  slot_index;

	modport source (output valid, cmd, doc_id, owner_id, slot_index, input ready);
	modport sink   (input valid, cmd, doc_id, owner_id, slot_index, output ready);
endinterface

interface plru_rsp_if import plru_pkg::*; #(
	parameter int DOC_ID_BITS   = DOC_ID_BITS_DEF,
	parameter int OWNER_ID_BITS = OWNER_ID_BITS_DEF
);
	logic                     valid;
	logic                     ready;
	logic [STATUS_BITS-1:0]   status;
	logic [SLOT_IN_BITS-1:0]  slot;
	logic [DOC_ID_BITS-1:0]   doc_out;
	logic [OWNER_ID_BITS-1:0] owner_out;
	logic                     evicted_valid;
	logic [DOC_ID_BITS-1:0]   evicted_doc;
	logic                     detached_valid;
	logic [OWNER_ID_BITS-1:0] detached_owner;
	logic                     assigned_new;
	logic [COUNT_BITS-1:0]    resident_count;
	logic                     last_result;

	modport source (output valid, status, slot, doc_out, owner_out, evicted_valid,
		evicted_doc, detached_valid, detached_owner, assigned_new, resident_count,
		last_result, input ready);
	modport sink   (input valid, status, slot, doc_out, owner_out, evicted_valid,
		evicted_doc, detached_valid, detached_owner, assigned_new, resident_count,
		last_result, output ready);
endinterface

interface plru_cfg_if import plru_pkg::*;;
	logic                valid;
	logic                ready;
	logic [CAP_BITS-1:0] capacity;

	modport source (output valid, capacity, input ready);
	modport sink   (input valid, capacity, output ready);
endinterface

[rtl/plru_cell.sv]
`timescale 1ns / 1ps
module plru_cell import plru_pkg::*; #(
	parameter int IDX           = 0,
	parameter int SW            = 3,
	parameter int DOC_ID_BITS   = DOC_ID_BITS_DEF,
	parameter int OWNER_ID_BITS = OWNER_ID_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cell_op_t                 op,
	input  logic [SW-1:0]            tgt,
	input  logic [SW-1:0]            ref_rank,
	input  logic [SW-1:0]            scan,
	input  logic [SLOT_IN_BITS-1:0]  sel,
	input  logic [DOC_ID_BITS-1:0]   key_doc,
	input  logic [OWNER_ID_BITS-1:0] key_own,
	input  flag_t                    chain_in,
	output flag_t                    chain_out,
	output flag_t                    mine,
	output logic                     vld,
	output logic [DOC_ID_BITS-1:0]   doc,
	output logic [OWNER_ID_BITS-1:0] own,
	output logic [SW-1:0]            rank
);

	logic                     vld_q;
	logic [DOC_ID_BITS-1:0]   doc_q;
	logic [OWNER_ID_BITS-1:0] own_q;
	logic [SW-1:0]            rank_q;
	logic                     is_tgt;

	assign is_tgt = (int'(tgt) == IDX);

	always_comb begin
		mine.doc  = vld_q && (doc_q == key_doc);
		mine.own  = vld_q && (own_q == key_own);
		mine.lru  = vld_q && (own_q == '0) && (rank_q == scan);
		mine.free = !vld_q;
		mine.sel  = (int'(sel) == IDX);
	end

	assign chain_out = flag_t'(chain_in | mine);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= 1'b0;
			own_q  <= '0;
			rank_q <= '0;
		end else begin
			case (op)
				C_UNPIN: begin
					if (is_tgt) own_q <= '0;
				end
				C_TOUCH: begin
					if (is_tgt) begin
						own_q  <= key_own;
						rank_q <= '0;
					end else if (vld_q && rank_q < ref_rank) begin
						rank_q <= rank_q + 1'b1;
					end
				end
				C_FILL: begin
					if (is_tgt) begin
						vld_q  <= 1'b1;
						own_q  <= key_own;
						rank_q <= '0;
					end else if (vld_q) begin
						rank_q <= rank_q + 1'b1;
					end
				end
				C_DROP: begin
					if (is_tgt) begin
						vld_q  <= 1'b0;
						own_q  <= '0;
						rank_q <= '0;
					end else if (vld_q && rank_q > ref_rank) begin
						rank_q <= rank_q - 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// document is written only on a touch or fill aimed at this cell
	always_ff @(posedge clk) begin
		if ((op == C_TOUCH || op == C_FILL) && is_tgt) doc_q <= key_doc;
	end

	assign vld  = vld_q;
	assign doc  = doc_q;
	assign own  = own_q;
	assign rank = rank_q;

endmodule

[rtl/pinned_lru_slot_pool.sv]
`timescale 1ns / 1ps
// Sequencing: release/forget/lookup/read load their result in dispatch; an acquire
//   that hits or fills loads it in the acquire state, or after a rank scan to evict.
// Throughput: one item at a time; trim emits one item per eviction, each eviction
//   costing a scan of the recency ranks through the cell row.
// Reset (arst_n low, async): all entries empty, owners and ranks zero, capacity 8.
module pinned_lru_slot_pool import plru_pkg::*; #(
	parameter int SLOTS         = SLOTS_DEF,
	parameter int DOC_ID_BITS   = DOC_ID_BITS_DEF,
	parameter int OWNER_ID_BITS = OWNER_ID_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	plru_req_if.sink    req,
	plru_rsp_if.source  rsp,
	plru_cfg_if.sink    cfg
);

	localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;  // slot index / rank width
	localparam int CW = $clog2(SLOTS + 1);                // resident count width

	// ---------------- configuration ----------------
	logic [CAP_BITS-1:0] cap_q;
	logic [CW-1:0]       cap_eff;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cap_q <= CAP_BITS'(8);
		else if (cfg.valid) cap_q <= cfg.capacity;
	end

	// zero acts as one, anything past the pool size clamps to it
	always_comb begin
		if (cap_q == '0) cap_eff = CW'(1);
		else if (int'(cap_q) > SLOTS) cap_eff = CW'(SLOTS);
		else cap_eff = CW'(cap_q);
	end

	// ---------------- latched item ----------------
	state_t                   st_q, st_d;
	logic [CMD_BITS-1:0]      cmd_q;
	logic [DOC_ID_BITS-1:0]   doc_q;
	logic [OWNER_ID_BITS-1:0] own_q;
	logic [SLOT_IN_BITS-1:0]  si_q;
	logic [CW-1:0]            count_q, cnt_d;
	logic [RES_CNT_BITS-1:0]  k_q, k_d;
	logic [SW-1:0]            scan_q, scan_d;

	assign req.ready = (st_q == S_IDLE);

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			cmd_q <= req.cmd;
			doc_q <= req.doc_id;
			own_q <= req.owner_id;
			si_q  <= req.slot_index;
		end
	end

	// ---------------- cell row ----------------
	// Each cell holds one entry. Match flags ripple left to right so the first
	// free slot wins; doc, owner and LRU candidates are unique by construction.
	cell_op_t                 cop;
	logic [SW-1:0]            ctgt, cref;
	flag_t                    chain [SLOTS+1];
	flag_t                    mine  [SLOTS];
	logic [SLOTS-1:0]         vld;
	logic [DOC_ID_BITS-1:0]   cdoc  [SLOTS];
	logic [OWNER_ID_BITS-1:0] cown  [SLOTS];
	logic [SW-1:0]            crank [SLOTS];

	assign chain[0] = '0;

	for (genvar g = 0; g < SLOTS; g++) begin : g_cell
		plru_cell #(
			.IDX(g), .SW(SW), .DOC_ID_BITS(DOC_ID_BITS), .OWNER_ID_BITS(OWNER_ID_BITS)
		) u_cell (
			.clk, .arst_n,
			.op(cop), .tgt(ctgt), .ref_rank(cref), .scan(scan_q), .sel(si_q),
			.key_doc(doc_q), .key_own(own_q),
			.chain_in(chain[g]), .chain_out(chain[g+1]), .mine(mine[g]),
			.vld(vld[g]), .doc(cdoc[g]), .own(cown[g]), .rank(crank[g])
		);
	end

	// gather the first taker of each search (AND-OR mux)
	logic [SW-1:0]            d_idx, o_idx, l_idx, f_idx, d_rank;
	logic [OWNER_ID_BITS-1:0] d_own, s_own;
	logic [DOC_ID_BITS-1:0]   o_doc, l_doc, s_doc;
	logic                     s_vld;
	logic                     d_hit, o_hit, l_hit;
	flag_t                    tk;

	assign d_hit = chain[SLOTS].doc;
	assign o_hit = chain[SLOTS].own;
	assign l_hit = chain[SLOTS].lru;

	always_comb begin
		d_idx = '0; o_idx = '0; l_idx = '0; f_idx = '0; d_rank = '0;
		d_own = '0; s_own = '0; o_doc = '0; l_doc = '0; s_doc = '0; s_vld = 1'b0;
		tk = '0;
		for (int i = 0; i < SLOTS; i++) begin
			tk = flag_t'(mine[i] & ~chain[i]);
			if (tk.doc) begin
				d_idx  = d_idx | SW'(i);
				d_rank = d_rank | crank[i];
				d_own  = d_own | cown[i];
			end
			if (tk.own) begin
				o_idx = o_idx | SW'(i);
				o_doc = o_doc | cdoc[i];
			end
			if (tk.lru) begin
				l_idx = l_idx | SW'(i);
				l_doc = l_doc | cdoc[i];
			end
			if (tk.free) f_idx = f_idx | SW'(i);
			if (tk.sel) begin
				s_vld = s_vld | vld[i];
				s_doc = s_doc | cdoc[i];
				s_own = s_own | cown[i];
			end
		end
	end

	// ---------------- result register ----------------
	logic                     o_free, ld;
	logic                     out_vld_q;
	logic [STATUS_BITS-1:0]   r_status;
	logic [SW-1:0]            r_slot;
	logic [DOC_ID_BITS-1:0]   r_doc, r_evd;
	logic [OWNER_ID_BITS-1:0] r_own, r_det_own;
	logic                     r_ev, r_det, r_asg, r_last;

	assign o_free = !out_vld_q || rsp.ready;

	// ---------------- control ----------------
	always_comb begin
		st_d = st_q;
		cop = C_NOP; ctgt = '0; cref = '0;
		ld = 1'b0;
		r_status = STAT_OK; r_slot = '0; r_doc = '0; r_own = '0;
		r_ev = 1'b0; r_evd = '0; r_det = 1'b0; r_det_own = '0; r_asg = 1'b0;
		r_last = 1'b1;
		cnt_d = count_q; k_d = k_q; scan_d = scan_q;

		unique case (st_q)
			S_IDLE: begin
				if (req.valid) st_d = S_DISP;
			end
			S_DISP: begin
				if (o_free) begin
					st_d = S_IDLE;
					unique case (cmd_q)
						CMD_ACQUIRE: begin
							if (doc_q == '0 || own_q == '0) begin
								ld = 1'b1; r_status = STAT_MISSING;
							end else begin
								// owner moves on: its previous entry loses the pin
								if (o_hit && o_doc != doc_q) begin
									cop = C_UNPIN; ctgt = o_idx;
								end
								st_d = S_ACQ;
							end
						end
						CMD_RELEASE: begin
							ld = 1'b1;
							if (own_q == '0) r_status = STAT_MISSING;
							else if (!o_hit) r_status = STAT_NOT_FOUND;
							else begin
								cop = C_UNPIN; ctgt = o_idx;
								r_slot = o_idx; r_doc = o_doc;
							end
						end
						CMD_FORGET: begin
							ld = 1'b1;
							if (doc_q == '0) r_status = STAT_MISSING;
							else if (!d_hit) r_status = STAT_NOT_FOUND;
							else begin
								cop = C_DROP; ctgt = d_idx; cref = d_rank;
								cnt_d = count_q - 1'b1;
								r_slot = d_idx; r_ev = 1'b1; r_evd = doc_q;
							end
						end
						CMD_LOOKUP: begin
							ld = 1'b1;
							if (doc_q == '0) r_status = STAT_MISSING;
							else if (!d_hit) r_status = STAT_NOT_FOUND;
							else begin
								r_slot = d_idx; r_doc = doc_q; r_own = d_own;
							end
						end
						CMD_READ: begin
							ld = 1'b1;
							r_slot = SW'(si_q);
							if (int'(si_q) < SLOTS && s_vld) begin
								r_doc = s_doc; r_own = s_own;
							end else begin
								r_status = STAT_NOT_FOUND;
							end
						end
						CMD_TRIM: begin
							k_d = '0;
							st_d = S_TRIM;
						end
						default: begin
							ld = 1'b1; r_status = STAT_NOT_FOUND;
						end
					endcase
				end
			end
			S_ACQ: begin
				if (o_free) begin
					if (d_hit) begin
						// handoff: hit entry takes the new owner and becomes MRU
						cop = C_TOUCH; ctgt = d_idx; cref = d_rank;
						ld = 1'b1; st_d = S_IDLE;
						r_slot = d_idx; r_doc = doc_q; r_own = own_q;
						if (d_own != '0 && d_own != own_q) begin
							r_det = 1'b1; r_det_own = d_own;
						end
					end else if (count_q < cap_eff) begin
						cop = C_FILL; ctgt = f_idx;
						cnt_d = count_q + 1'b1;
						ld = 1'b1; st_d = S_IDLE;
						r_slot = f_idx; r_doc = doc_q; r_own = own_q; r_asg = 1'b1;
					end else begin
						scan_d = SW'(CW'(count_q - 1'b1));
						st_d = S_SCAN;
					end
				end
			end
			S_SCAN: begin
				// walk ranks from oldest down until an unpinned entry answers
				if (l_hit) begin
					if (o_free) begin
						ld = 1'b1;
						r_slot = l_idx; r_ev = 1'b1; r_evd = l_doc;
						if (cmd_q == CMD_ACQUIRE) begin
							cop = C_TOUCH; ctgt = l_idx; cref = scan_q;
							r_doc = doc_q; r_own = own_q; r_asg = 1'b1;
							st_d = S_IDLE;
						end else begin
							cop = C_DROP; ctgt = l_idx; cref = scan_q;
							cnt_d = count_q - 1'b1;
							k_d = k_q + 1'b1;
							r_last = (k_q == RES_CNT_BITS'(MAX_RESULTS - 1)) ||
								(cnt_d <= cap_eff);
							st_d = r_last ? S_IDLE : S_TRIM;
						end
					end
				end else if (scan_q != '0) begin
					scan_d = scan_q - 1'b1;
				end else if (o_free) begin
					ld = 1'b1; r_status = STAT_PINNED; st_d = S_IDLE;
				end
			end
			S_TRIM: begin
				if (k_q < RES_CNT_BITS'(MAX_RESULTS) && count_q > cap_eff) begin
					scan_d = SW'(CW'(count_q - 1'b1));
					st_d = S_SCAN;
				end else if (o_free) begin
					// nothing to evict
					ld = 1'b1; st_d = S_IDLE;
				end
			end
			default: st_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= S_IDLE;
			count_q   <= '0;
			k_q       <= '0;
			scan_q    <= '0;
			out_vld_q <= 1'b0;
		end else begin
			st_q    <= st_d;
			count_q <= cnt_d;
			k_q     <= k_d;
			scan_q  <= scan_d;
			if (ld) out_vld_q <= 1'b1;
			else if (rsp.ready) out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			rsp.status         <= r_status;
			rsp.slot           <= SLOT_IN_BITS'(r_slot);
			rsp.doc_out        <= r_doc;
			rsp.owner_out      <= r_own;
			rsp.evicted_valid  <= r_ev;
			rsp.evicted_doc    <= r_evd;
			rsp.detached_valid <= r_det;
			rsp.detached_owner <= r_det_own;
			rsp.assigned_new   <= r_asg;
			rsp.resident_count <= COUNT_BITS'(cnt_d);
			rsp.last_result    <= r_last;
		end
	end

	assign rsp.valid = out_vld_q;

	// ---------------- checks ----------------
	logic [SLOTS-1:0] doc_m, own_m;
	always_comb begin
		for (int i = 0; i < SLOTS; i++) begin
			doc_m[i] = mine[i].doc;
			own_m[i] = mine[i].own;
		end
	end

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(vld) == int'(count_q))
		else $error("resident count out of step with valid entries");

	a_doc_unique: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(doc_m))
		else $error("document resident twice");

	a_own_unique: assert property (@(posedge clk) disable iff (!arst_n)
		own_q != '0 |-> $onehot0(own_m))
		else $error("owner pins two entries");

	a_no_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ld |-> !out_vld_q || rsp.ready)
		else $error("result overwritten before taken");

endmodule
